@@ sv/gda_pkg.sv @@
// Shared types, constants and calendar helpers for the Gregorian date adder.
package gda_pkg;

    // Field widths of the item and result channels.
    localparam int FIELD_YEAR_BITS  = 16;
    localparam int FIELD_INC_BITS   = 16;
    localparam int FIELD_MONTH_BITS = 4;
    localparam int FIELD_DAY_BITS   = 5;

    // Calendar constants.
    localparam int MONTHS_PER_YEAR  = 12;
    localparam int CYCLE_YEARS      = 400;
    localparam int CENTURY_YEARS    = 100;
    localparam int LEAP_FEB_DAYS    = 29;
    localparam int COMMON_FEB_DAYS  = 28;
    localparam int SHORT_MONTH_DAYS = 30;
    localparam int LONG_MONTH_DAYS  = 31;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    // Width of a remainder modulo 400.
    localparam int CYCLE_REM_BITS = 9;

    // Division by 3 as a multiply by ceil(2^17 / 3); exact for dividends below 2^17.
    localparam int          DIV3_RECIP_BITS = 16;
    localparam int          DIV3_SHIFT      = 17;
    localparam logic [15:0] DIV3_RECIP      = 16'd43691;

    typedef enum logic [1:0] {
        OP_SET        = 2'd0,
        OP_ADD_YEARS  = 2'd1,
        OP_ADD_MONTHS = 2'd2,
        OP_ADD_DAYS   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_MOD_START,
        ST_MOD_RUN,
        ST_DAY_LOOP,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic reject;
        logic load_set;
        logic load_years;
        logic divide;
        logic load_months;
        logic load_days;
        logic mod_start;
        logic day_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic unset;
        logic mod_busy;
        logic loop_done;
        logic out_busy;
    } status_t;

    // Leap test from the year's remainder modulo 400.
    function automatic logic leap_from_rem(input logic [CYCLE_REM_BITS-1:0] rem);
        logic century;
        century = (rem == CYCLE_REM_BITS'(CENTURY_YEARS))
               || (rem == CYCLE_REM_BITS'(2 * CENTURY_YEARS))
               || (rem == CYCLE_REM_BITS'(3 * CENTURY_YEARS));
        return (rem[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [FIELD_DAY_BITS-1:0] month_len(input logic leap,
                                                            input logic [3:0] month);
        logic [FIELD_DAY_BITS-1:0] len;
        case (month)
            MONTH_FEB:
            begin
                len = leap ? FIELD_DAY_BITS'(LEAP_FEB_DAYS) : FIELD_DAY_BITS'(COMMON_FEB_DAYS);
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV:
            begin
                len = FIELD_DAY_BITS'(SHORT_MONTH_DAYS);
            end
            default:
            begin
                len = FIELD_DAY_BITS'(LONG_MONTH_DAYS);
            end
        endcase
        return len;
    endfunction

endpackage

@@ sv/gda_in_if.sv @@
// Item channel: one date operation per transaction.
interface gda_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [15:0] increment;

    modport source (output valid, output operation, output new_year, output new_month,
                    output new_day, output increment, input ready);
    modport sink   (input valid, input operation, input new_year, input new_month,
                    input new_day, input increment, output ready);
endinterface

@@ sv/gda_out_if.sv @@
// Result channel: the stored date and the accepted flag after each item.
interface gda_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic        accepted;

    modport source (output valid, output cur_year, output cur_month, output cur_day,
                    output accepted, input ready);
    modport sink   (input valid, input cur_year, input cur_month, input cur_day,
                    input accepted, output ready);
endinterface

@@ sv/gregorian_date_adder_top.sv @@
// Top level of the Gregorian date adder: controller, datapath and channel wiring.
//
// The block holds one date. Each transaction on the item channel sets the date or
// adds years, months or days; each produces exactly one transaction on the result
// channel with the stored date afterwards and an accepted flag (0 when rejected).
// Items are worked one at a time. A set or a year add passes through decode, the
// modulo start and modulo run states and commit, and the next item is accepted once
// the controller is back in idle; most of the time goes to reducing the year modulo
// 400 for the leap test, a reciprocal multiplication spread over registered steps.
// A month add has one more state, a divide step for the split of the month count
// into years and months. After those steps a day add walks one calendar month per
// cycle, up to about 2160 months for a 16-bit increment. An add on a date that was
// never set is rejected at decode. The result sits in an output register: while the
// receiver stalls, the next item is still accepted and worked, and it waits only at
// its final commit step. Reset is asynchronous: the date returns to zero (unset),
// the state machine idles and no result is pending.
module gregorian_date_adder_top #(
    parameter int YEAR_BITS      = 16,
    parameter int INCREMENT_BITS = 16
) (
    input logic             clk,
    input logic             rst_n,
    gda_in_if.sink          item,
    gda_out_if.source       result
);

    gda_pkg::cmd_t    cmd;
    gda_pkg::status_t status;

    gda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gda_dpath #(
        .YEAR_BITS      (YEAR_BITS),
        .INCREMENT_BITS (INCREMENT_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .operation (item.operation),
        .new_year  (item.new_year),
        .new_month (item.new_month),
        .new_day   (item.new_day),
        .increment (item.increment),
        .cur_year  (result.cur_year),
        .cur_month (result.cur_month),
        .cur_day   (result.cur_day),
        .accepted  (result.accepted),
        .out_valid (result.valid),
        .out_ready (result.ready)
    );

endmodule

@@ sv/gda_mod400.sv @@
// Remainder of a year modulo 400 by reciprocal multiplication, with a single-step increment.
module gda_mod400 #(
    parameter int VALUE_BITS = 17
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  step,
    input  logic [VALUE_BITS-1:0]                 value,
    output logic                                  busy,
    output logic [gda_pkg::CYCLE_REM_BITS-1:0]    rem
);

    // 400 is 16 times 25: the low four bits pass straight through and the rest is
    // reduced modulo 25, so the remainder is 16 * (w mod 25) + low bits.
    localparam int LOW_BITS  = 4;
    localparam int R25_BITS  = 5;
    localparam int MOD25     = gda_pkg::CYCLE_YEARS >> LOW_BITS;
    localparam int WW        = VALUE_BITS - LOW_BITS;
    localparam int KW        = WW + 5;
    localparam int QW        = WW - 4;
    localparam int PW        = 2 * WW + 1;
    localparam int RW        = gda_pkg::CYCLE_REM_BITS;

    // ceil(2^KW / 25); the quotient it gives is exact for every WW-bit dividend.
    localparam logic [WW:0] RECIP = (WW + 1)'(((64'd1 << KW) + 64'd24) / 64'd25);

    localparam logic [1:0] CNT_QUOT = 2'd2;
    localparam logic [1:0] CNT_REM  = 2'd1;

    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic [WW-1:0]       w_reg;
    logic [LOW_BITS-1:0] low_reg;
    logic [QW-1:0]       q_reg;
    logic [RW-1:0]       rem_reg;
    logic [PW-1:0]       prod;
    logic [WW-1:0]       q25;
    logic [WW-1:0]       r25;
    logic [RW-1:0]       rem_inc;

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

    always_comb
    begin
        prod    = PW'(w_reg) * PW'(RECIP);
        q25     = WW'(q_reg) * WW'(MOD25);
        r25     = w_reg - q25;
        rem_inc = (rem_reg == RW'(gda_pkg::CYCLE_YEARS - 1)) ? '0 : rem_reg + 1'b1;
    end

    always_comb
    begin
        if (start)
        begin
            cnt_next = CNT_QUOT;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w_reg   <= value[VALUE_BITS-1:LOW_BITS];
            low_reg <= value[LOW_BITS-1:0];
        end
        else if (cnt_reg == CNT_QUOT)
        begin
            q_reg <= prod[KW +: QW];
        end
        else if (cnt_reg == CNT_REM)
        begin
            rem_reg <= {r25[R25_BITS-1:0], low_reg};
        end
        else if (step)
        begin
            rem_reg <= rem_inc;
        end
    end

endmodule

@@ sv/gda_ctrl.sv @@
// Controller state machine that sequences one date operation at a time.
module gda_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gda_pkg::status_t status,
    output gda_pkg::cmd_t    cmd
);

    gda_pkg::state_t state_reg;
    gda_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gda_pkg::ST_DECODE;
                end
            end
            gda_pkg::ST_DECODE:
            begin
                if (status.op == gda_pkg::OP_SET)
                begin
                    state_next = gda_pkg::ST_MOD_START;
                end
                else if (status.unset)
                begin
                    state_next = gda_pkg::ST_COMMIT;
                end
                else if (status.op == gda_pkg::OP_ADD_MONTHS)
                begin
                    state_next = gda_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = gda_pkg::ST_MOD_START;
                end
            end
            gda_pkg::ST_DIVIDE:
            begin
                state_next = gda_pkg::ST_MOD_START;
            end
            gda_pkg::ST_MOD_START:
            begin
                state_next = gda_pkg::ST_MOD_RUN;
            end
            gda_pkg::ST_MOD_RUN:
            begin
                if (!status.mod_busy)
                begin
                    state_next = (status.op == gda_pkg::OP_ADD_DAYS) ?
                                 gda_pkg::ST_DAY_LOOP : gda_pkg::ST_COMMIT;
                end
            end
            gda_pkg::ST_DAY_LOOP:
            begin
                if (status.loop_done)
                begin
                    state_next = gda_pkg::ST_COMMIT;
                end
            end
            gda_pkg::ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = gda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            gda_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            gda_pkg::ST_DECODE:
            begin
                if (status.op == gda_pkg::OP_SET)
                begin
                    cmd.load_set = 1'b1;
                end
                else if (status.unset)
                begin
                    cmd.reject = 1'b1;
                end
                else
                begin
                    case (status.op)
                        gda_pkg::OP_ADD_YEARS:  cmd.load_years = 1'b1;
                        gda_pkg::OP_ADD_MONTHS: cmd.divide     = 1'b1;
                        gda_pkg::OP_ADD_DAYS:   cmd.load_days  = 1'b1;
                        default:                cmd.reject     = 1'b1;
                    endcase
                end
            end
            gda_pkg::ST_DIVIDE:
            begin
                cmd.load_months = 1'b1;
            end
            gda_pkg::ST_MOD_START:
            begin
                cmd.mod_start = 1'b1;
            end
            gda_pkg::ST_DAY_LOOP:
            begin
                cmd.day_step = !status.loop_done;
            end
            gda_pkg::ST_COMMIT:
            begin
                cmd.commit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/gda_dpath.sv @@
// Datapath: captured item, candidate date, month divider, day walk, stored date and result register.
module gda_dpath #(
    parameter int YEAR_BITS      = 16,
    parameter int INCREMENT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gda_pkg::cmd_t    cmd,
    output gda_pkg::status_t status,
    input  logic [1:0]       operation,
    input  logic [15:0]      new_year,
    input  logic [3:0]       new_month,
    input  logic [4:0]       new_day,
    input  logic [15:0]      increment,
    output logic [15:0]      cur_year,
    output logic [3:0]       cur_month,
    output logic [4:0]       cur_day,
    output logic             accepted,
    output logic             out_valid,
    input  logic             out_ready
);

    localparam int IW = (INCREMENT_BITS < gda_pkg::FIELD_INC_BITS) ?
                        INCREMENT_BITS : gda_pkg::FIELD_INC_BITS;
    localparam int CW = ((YEAR_BITS > gda_pkg::FIELD_YEAR_BITS) ?
                         YEAR_BITS : gda_pkg::FIELD_YEAR_BITS) + 1;
    localparam int DW = IW + 1;
    localparam int TW = IW + 1;
    localparam int XW = IW - 1;
    localparam int QW = IW - 2;
    localparam int PW = XW + gda_pkg::DIV3_RECIP_BITS;
    localparam int MW = gda_pkg::FIELD_MONTH_BITS;
    localparam int RW = gda_pkg::CYCLE_REM_BITS;

    // Captured item.
    gda_pkg::op_t    op_reg;
    logic [15:0]     new_year_reg;
    logic [MW-1:0]   new_month_reg;
    logic [4:0]      new_day_reg;
    logic [IW-1:0]   inc_reg;

    // Working candidate date.
    logic            rej_reg;
    logic [CW-1:0]   y_reg;
    logic [MW-1:0]   m_reg;
    logic [DW-1:0]   d_reg;
    logic [TW-1:0]   t_reg;
    logic [QW-1:0]   q_reg;

    // Stored date.
    logic [YEAR_BITS-1:0] year_reg;
    logic [MW-1:0]        month_reg;
    logic [4:0]           day_reg;

    // Result register.
    logic [15:0]   cur_year_reg;
    logic [MW-1:0] cur_month_reg;
    logic [4:0]    cur_day_reg;
    logic          accepted_reg;
    logic          out_valid_reg;

    logic          mod_busy;
    logic [RW-1:0] rem;
    logic          leap;
    logic [4:0]    mlen;
    logic          y_over;
    logic          loop_done;
    logic          date_ok;
    logic [TW-1:0] t_next;
    logic [XW-1:0] x;
    logic [PW-1:0] prod;
    logic [TW-1:0] q12;
    logic [TW-1:0] rem12;
    logic          wrap;

    gda_mod400 #(
        .VALUE_BITS (CW)
    ) u_mod400 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mod_start),
        .step  (wrap),
        .value (y_reg),
        .busy  (mod_busy),
        .rem   (rem)
    );

    always_comb
    begin
        leap      = gda_pkg::leap_from_rem(rem);
        mlen      = gda_pkg::month_len(leap, m_reg);
        y_over    = |y_reg[CW-1:YEAR_BITS];
        loop_done = y_over || (d_reg <= DW'(mlen));
        date_ok   = !rej_reg && !y_over && (y_reg != '0)
                 && (m_reg != '0) && (m_reg <= MW'(gda_pkg::MONTHS_PER_YEAR))
                 && (d_reg != '0) && (d_reg <= DW'(mlen));
        wrap      = cmd.day_step && (m_reg == MW'(gda_pkg::MONTHS_PER_YEAR));

        // Months since January of the stored year, then split into years and months.
        t_next = TW'(month_reg - 1'b1) + TW'(inc_reg);
        x      = t_next[TW-1:2];
        prod   = PW'(x) * PW'(gda_pkg::DIV3_RECIP);
        q12    = (TW'(q_reg) << 3) + (TW'(q_reg) << 2);
        rem12  = t_reg - q12;
    end

    assign status.op        = op_reg;
    assign status.unset     = (month_reg == '0);
    assign status.mod_busy  = mod_busy;
    assign status.loop_done = loop_done;
    assign status.out_busy  = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= gda_pkg::op_t'(operation);
            new_year_reg  <= new_year;
            new_month_reg <= new_month;
            new_day_reg   <= new_day;
            inc_reg       <= increment[IW-1:0];
            rej_reg       <= 1'b0;
        end
        if (cmd.reject)
        begin
            rej_reg <= 1'b1;
        end
        if (cmd.divide)
        begin
            t_reg <= t_next;
            q_reg <= prod[gda_pkg::DIV3_SHIFT +: QW];
        end
        if (cmd.load_set)
        begin
            y_reg <= CW'(new_year_reg);
            m_reg <= new_month_reg;
            d_reg <= DW'(new_day_reg);
        end
        else if (cmd.load_years)
        begin
            y_reg <= CW'(year_reg) + CW'(inc_reg);
            m_reg <= month_reg;
            d_reg <= DW'(day_reg);
        end
        else if (cmd.load_months)
        begin
            y_reg <= CW'(year_reg) + CW'(q_reg);
            m_reg <= rem12[MW-1:0] + 1'b1;
            d_reg <= DW'(day_reg);
        end
        else if (cmd.load_days)
        begin
            y_reg <= CW'(year_reg);
            m_reg <= month_reg;
            d_reg <= DW'(day_reg) + DW'(inc_reg);
        end
        else if (cmd.day_step)
        begin
            // Walk forward one month, carrying into the year after December.
            d_reg <= d_reg - DW'(mlen);
            if (wrap)
            begin
                m_reg <= MW'(1);
                y_reg <= y_reg + 1'b1;
            end
            else
            begin
                m_reg <= m_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= '0;
            month_reg <= '0;
            day_reg   <= '0;
        end
        else if (cmd.commit && date_ok)
        begin
            year_reg  <= y_reg[YEAR_BITS-1:0];
            month_reg <= m_reg;
            day_reg   <= d_reg[4:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            cur_year_reg  <= date_ok ? 16'(y_reg[YEAR_BITS-1:0]) : 16'(year_reg);
            cur_month_reg <= date_ok ? m_reg : month_reg;
            cur_day_reg   <= date_ok ? d_reg[4:0] : day_reg;
            accepted_reg  <= date_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign cur_year  = cur_year_reg;
    assign cur_month = cur_month_reg;
    assign cur_day   = cur_day_reg;
    assign accepted  = accepted_reg;
    assign out_valid = out_valid_reg;

endmodule
